// File: design/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, opcode and function codes and event codes for the
// integer subset instruction executor.
// ----------------------------------------------------------------------------
package mse_pkg;

    // default sizes
    localparam int PROGRAM_DEPTH_DFLT = 1024;
    localparam int NUM_REGS_DFLT      = 32;

    // fixed field widths
    localparam int INSTR_W   = 32;
    localparam int DATA_W    = 32;
    localparam int NEXT_PC_W = 10;
    localparam int EVENT_W   = 3;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_SPECIAL2 = 6'h1C;

    // function codes
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_MUL     = 6'h02;

    // syscall services and the registers they use
    localparam logic [DATA_W-1:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [DATA_W-1:0] SYS_EXIT       = 32'd10;
    localparam logic [DATA_W-1:0] SYS_PRINT_CHAR = 32'd11;
    localparam logic [4:0]        REG_V0         = 5'd2;
    localparam logic [4:0]        REG_A0         = 5'd4;

    // result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PINT    = 3'd1,
        EV_PCHAR   = 3'd2,
        EV_EXIT    = 3'd3,
        EV_UNKNOWN = 3'd4,
        EV_INVALID = 3'd5,
        EV_RANGE   = 3'd6,
        EV_HALTED  = 3'd7
    } event_t;

endpackage

// File: design/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic single write port, single read port RAM with registered read data
// (read-first on an address collision).
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/mips_subset_executor_top.sv
// Results: the execute stage register feeds the result register (out_valid).
// Throughput: one instruction per cycle while out_stall is low; the execute
// path (register read with forwarding, 32x32 multiplier, writeback select) sets it.
// Reset: program counter, halt flag, register valid bits and the v0/a0 copies
// clear at once; registers never written read as zero, no clearing pass.
// ----------------------------------------------------------------------------
// mips_subset_executor_top
// Executes one instruction word per transfer against a 32 x 32-bit register
// file and returns the next instruction index and an event code.
// ----------------------------------------------------------------------------
module mips_subset_executor_top #(
    parameter int PROGRAM_DEPTH = mse_pkg::PROGRAM_DEPTH_DFLT,
    parameter int NUM_REGS      = mse_pkg::NUM_REGS_DFLT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mse_pkg::INSTR_W-1:0]          instruction,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mse_pkg::NEXT_PC_W-1:0]        next_pc,
    output logic [mse_pkg::EVENT_W-1:0]          event_res,
    output logic signed [mse_pkg::DATA_W-1:0]    event_value
);

    import mse_pkg::*;

    localparam int PC_W   = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int REG_AW = $clog2(NUM_REGS);

    // handshake and stage control
    logic                  stage_valid_reg;
    logic                  out_valid_reg;
    logic                  in_xfer;
    logic                  advance;

    // execute stage payload
    logic [INSTR_W-1:0]    instr_reg;
    logic                  rs_ok_reg;
    logic                  rt_ok_reg;

    // architectural state
    logic [PC_W-1:0]       pc_reg;
    logic                  halted_reg;
    logic [NUM_REGS-1:0]   valid_bits_reg;
    logic [DATA_W-1:0]     v0_reg;
    logic [DATA_W-1:0]     a0_reg;

    // last register write, for forwarding past the ram read
    logic                  fwd_en_reg;
    logic [REG_AW-1:0]     fwd_addr_reg;
    logic [DATA_W-1:0]     fwd_data_reg;

    // result register
    logic [NEXT_PC_W-1:0]  next_pc_reg;
    event_t                event_reg;
    logic [DATA_W-1:0]     event_value_reg;

    // decoded fields
    logic [5:0]            op;
    logic [5:0]            fn;
    logic [REG_AW-1:0]     rs;
    logic [REG_AW-1:0]     rt;
    logic [REG_AW-1:0]     rd;
    logic [15:0]           imm;
    logic [DATA_W-1:0]     imm_sext;
    logic [DATA_W-1:0]     imm_zext;
    logic [REG_AW-1:0]     rs_in;
    logic [REG_AW-1:0]     rt_in;

    // operands
    logic [DATA_W-1:0]     ram_a;
    logic [DATA_W-1:0]     ram_b;
    logic [DATA_W-1:0]     opa;
    logic [DATA_W-1:0]     opb;
    logic [DATA_W-1:0]     product;
    logic [DATA_W-1:0]     target;
    logic                  target_bad;
    logic                  taken;
    logic [PC_W-1:0]       pc_seq;

    // execute results
    logic                  wr_req;
    logic                  wr_en;
    logic [REG_AW-1:0]     wr_addr;
    logic [DATA_W-1:0]     wr_data;
    logic                  halt_set;
    logic [PC_W-1:0]       pc_next;
    event_t                event_next;
    logic [DATA_W-1:0]     event_value_next;

    // handshake: the stage empties whenever the result register can load
    assign advance  = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign rs_in = REG_AW'(instruction[25:21]);
    assign rt_in = REG_AW'(instruction[20:16]);

    // register file, one copy per source operand
    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_xfer),
        .rd_addr (rs_in),
        .rd_data (ram_a)
    );

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_xfer),
        .rd_addr (rt_in),
        .rd_data (ram_b)
    );

    // field extraction
    assign op       = instr_reg[31:26];
    assign fn       = instr_reg[5:0];
    assign rs       = REG_AW'(instr_reg[25:21]);
    assign rt       = REG_AW'(instr_reg[20:16]);
    assign rd       = REG_AW'(instr_reg[15:11]);
    assign imm      = instr_reg[15:0];
    assign imm_sext = {{16{imm[15]}}, imm};
    assign imm_zext = {16'h0000, imm};

    // operand select: newest write, else stored value, else reset zero
    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == rs))
        begin
            opa = fwd_data_reg;
        end
        else
        begin
            opa = rs_ok_reg ? ram_a : '0;
        end
        if (fwd_en_reg && (fwd_addr_reg == rt))
        begin
            opb = fwd_data_reg;
        end
        else
        begin
            opb = rt_ok_reg ? ram_b : '0;
        end
    end

    // multiplier, branch target and sequential pc
    assign product    = opa * opb;
    assign target     = DATA_W'(pc_reg) + imm_sext;
    assign target_bad = target[DATA_W-1] || (target >= DATA_W'(PROGRAM_DEPTH));
    assign taken      = (op == OP_BEQ) ? (opa == opb) : (opa != opb);
    assign pc_seq     = (pc_reg == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : pc_reg + 1'b1;

    // instruction decode and execute
    always_comb
    begin
        wr_req           = 1'b0;
        wr_addr          = rd;
        wr_data          = '0;
        halt_set         = 1'b0;
        pc_next          = pc_seq;
        event_next       = EV_NONE;
        event_value_next = '0;

        if (halted_reg)
        begin
            pc_next    = pc_reg;
            event_next = EV_HALTED;
        end
        else if ((op == OP_SPECIAL) && (fn == FN_SYSCALL))
        begin
            if (v0_reg == SYS_PRINT_INT)
            begin
                event_next       = EV_PINT;
                event_value_next = a0_reg;
            end
            else if (v0_reg == SYS_PRINT_CHAR)
            begin
                event_next       = EV_PCHAR;
                event_value_next = a0_reg;
            end
            else if (v0_reg == SYS_EXIT)
            begin
                halt_set   = 1'b1;
                pc_next    = pc_reg;
                event_next = EV_EXIT;
            end
            else
            begin
                halt_set         = 1'b1;
                pc_next          = pc_reg;
                event_next       = EV_UNKNOWN;
                event_value_next = v0_reg;
            end
        end
        else
        begin
            unique case (op) inside
                OP_SPECIAL:
                begin
                    wr_req = 1'b1;
                    unique case (fn)
                        FN_ADD: wr_data = opa + opb;
                        FN_SUB: wr_data = opa - opb;
                        FN_AND: wr_data = opa & opb;
                        FN_OR:  wr_data = opa | opb;
                        FN_SLT: wr_data = DATA_W'($signed(opa) < $signed(opb));
                        default:
                        begin
                            wr_req           = 1'b0;
                            halt_set         = 1'b1;
                            pc_next          = pc_reg;
                            event_next       = EV_INVALID;
                            event_value_next = instr_reg;
                        end
                    endcase
                end
                OP_SPECIAL2:
                begin
                    if (fn == FN_MUL)
                    begin
                        wr_req  = 1'b1;
                        wr_data = product;
                    end
                    else
                    begin
                        halt_set         = 1'b1;
                        pc_next          = pc_reg;
                        event_next       = EV_INVALID;
                        event_value_next = instr_reg;
                    end
                end
                OP_BEQ, OP_BNE:
                begin
                    if (taken && target_bad)
                    begin
                        halt_set         = 1'b1;
                        pc_next          = pc_reg;
                        event_next       = EV_RANGE;
                        event_value_next = target;
                    end
                    else if (taken)
                    begin
                        pc_next = target[PC_W-1:0];
                    end
                end
                OP_ADDI:
                begin
                    wr_req  = 1'b1;
                    wr_addr = rt;
                    wr_data = opa + imm_sext;
                end
                OP_SLTI:
                begin
                    wr_req  = 1'b1;
                    wr_addr = rt;
                    wr_data = DATA_W'($signed(opa) < $signed(imm_sext));
                end
                OP_ANDI:
                begin
                    wr_req  = 1'b1;
                    wr_addr = rt;
                    wr_data = opa & imm_zext;
                end
                OP_ORI:
                begin
                    wr_req  = 1'b1;
                    wr_addr = rt;
                    wr_data = opa | imm_zext;
                end
                OP_LUI:
                begin
                    wr_req  = 1'b1;
                    wr_addr = rt;
                    wr_data = {imm, 16'h0000};
                end
                default:
                begin
                    halt_set         = 1'b1;
                    pc_next          = pc_reg;
                    event_next       = EV_INVALID;
                    event_value_next = instr_reg;
                end
            endcase
        end
    end

    // writes to $0 are dropped
    assign wr_en = advance && wr_req && (wr_addr != '0);

    // control state and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            pc_reg          <= '0;
            halted_reg      <= 1'b0;
            valid_bits_reg  <= '0;
            fwd_en_reg      <= 1'b0;
            v0_reg          <= '0;
            a0_reg          <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                pc_reg <= pc_next;
                if (halt_set)
                begin
                    halted_reg <= 1'b1;
                end
            end

            if (wr_en)
            begin
                valid_bits_reg[wr_addr] <= 1'b1;
                fwd_en_reg              <= 1'b1;
                if (wr_addr == REG_AW'(REG_V0))
                begin
                    v0_reg <= wr_data;
                end
                if (wr_addr == REG_AW'(REG_A0))
                begin
                    a0_reg <= wr_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            instr_reg <= instruction;
            rs_ok_reg <= valid_bits_reg[rs_in];
            rt_ok_reg <= valid_bits_reg[rt_in];
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (advance)
        begin
            next_pc_reg     <= NEXT_PC_W'(pc_next);
            event_reg       <= event_next;
            event_value_reg <= event_value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = next_pc_reg;
    assign event_res   = event_reg;
    assign event_value = event_value_reg;

    // once halted the block stays halted
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    // a halted block keeps its program counter
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> $stable(pc_reg))
        else $error("pc moved while halted");

    // every transfer executed after halting reports the halted event
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && halted_reg) |=> (out_valid && (event_res == EV_HALTED)))
        else $error("halted block gave a non-halted event");

    // register $0 is never written
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr != '0))
        else $error("write to register zero");

    // nothing is written while halted
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !wr_en)
        else $error("register write while halted");

endmodule

// File: test/mips_subset_executor_top_test.sv
// ----------------------------------------------------------------------------
// mips_subset_executor_top_test
// Feeds instruction words to the executor and checks every next_pc, event
// code and event value against a predictor with its own register file,
// program counter and halt flag. A directed program comes first, then random
// well-formed programs, then one halting instruction and a run of ignored
// words. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module mips_subset_executor_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    localparam int DEPTH = PROGRAM_DEPTH_DFLT;

    typedef struct {
        logic [31:0] word;
        bit          typed;
        logic [9:0]  pc;
        event_t      ev;
        logic [31:0] val;
    } step_row_t;

    typedef struct {
        logic [9:0]  pc;
        event_t      ev;
        logic [31:0] val;
    } result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [INSTR_W-1:0]        instruction;
    logic                      out_valid;
    logic                      out_stall;
    logic [NEXT_PC_W-1:0]      next_pc;
    logic [EVENT_W-1:0]        event_res;
    logic signed [DATA_W-1:0]  event_value;

    // predicted architectural state
    logic [31:0] gpr [32];
    int          prog_pc;
    bit          halted;

    result_t     pending_results [$];
    step_row_t   cur_row;
    step_row_t   directed_steps [$];
    int          mismatches;
    int          burst_left;
    bit          syscall_armed;

    mips_subset_executor_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .instruction (instruction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_pc     (next_pc),
        .event_res   (event_res),
        .event_value (event_value)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // instruction encoders
    function automatic logic [31:0] r_word(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [4:0] rd,
                                           input logic [4:0] sh, input logic [5:0] fn);
        return {op, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic step_row_t plain(input logic [31:0] w);
        step_row_t row;
        row = '{w, 1'b0, 10'd0, EV_NONE, 32'h0};
        return row;
    endfunction

    function automatic step_row_t typed(input logic [31:0] w, input logic [9:0] pc,
                                        input event_t ev, input logic [31:0] val);
        step_row_t row;
        row = '{w, 1'b1, pc, ev, val};
        return row;
    endfunction

    function automatic void write_reg(input logic [4:0] idx, input logic [31:0] v);
        if (idx != 5'd0)
            gpr[idx] = v;
    endfunction

    // predictor: executes one word, updates state, returns the result
    function automatic void execute_word(input logic [31:0] w, output result_t res);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [15:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] simm;
        logic [31:0] v0;
        bit          bad;
        bit          taken;
        int          tgt;

        op   = w[31:26];
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        fn   = w[5:0];
        imm  = w[15:0];
        a    = gpr[rs];
        b    = gpr[rt];
        simm = {{16{imm[15]}}, imm};
        v0   = gpr[REG_V0];
        bad  = 1'b0;
        res  = '{prog_pc[9:0], EV_NONE, 32'h0};

        if (halted)
        begin
            res.ev = EV_HALTED;
            return;
        end

        if (op == OP_SPECIAL && fn == FN_SYSCALL)
        begin
            if (v0 == SYS_PRINT_INT || v0 == SYS_PRINT_CHAR)
            begin
                res.ev  = (v0 == SYS_PRINT_INT) ? EV_PINT : EV_PCHAR;
                res.val = gpr[REG_A0];
            end
            else
            begin
                halted  = 1'b1;
                res.ev  = (v0 == SYS_EXIT) ? EV_EXIT : EV_UNKNOWN;
                res.val = (v0 == SYS_EXIT) ? 32'h0 : v0;
                return;
            end
        end
        else
        begin
            case (op)
                OP_SPECIAL:
                begin
                    case (fn)
                        FN_ADD:  write_reg(rd, a + b);
                        FN_SUB:  write_reg(rd, a - b);
                        FN_AND:  write_reg(rd, a & b);
                        FN_OR:   write_reg(rd, a | b);
                        FN_SLT:  write_reg(rd, 32'($signed(a) < $signed(b)));
                        default: bad = 1'b1;
                    endcase
                end
                OP_SPECIAL2:
                begin
                    if (fn == FN_MUL)
                        write_reg(rd, a * b);
                    else
                        bad = 1'b1;
                end
                OP_BEQ, OP_BNE:
                begin
                    taken = (op == OP_BEQ) ? (a == b) : (a != b);
                    if (taken)
                    begin
                        tgt = prog_pc + int'($signed(imm));
                        if (tgt < 0 || tgt >= DEPTH)
                        begin
                            halted  = 1'b1;
                            res.ev  = EV_RANGE;
                            res.val = 32'(tgt);
                            return;
                        end
                        prog_pc = tgt;
                        res.pc  = prog_pc[9:0];
                        return;
                    end
                end
                OP_ADDI: write_reg(rt, a + simm);
                OP_SLTI: write_reg(rt, 32'($signed(a) < $signed(simm)));
                OP_ANDI: write_reg(rt, a & {16'h0, imm});
                OP_ORI:  write_reg(rt, a | {16'h0, imm});
                OP_LUI:  write_reg(rt, {imm, 16'h0});
                default: bad = 1'b1;
            endcase
            if (bad)
            begin
                halted  = 1'b1;
                res.ev  = EV_INVALID;
                res.val = w;
                return;
            end
        end

        prog_pc = (prog_pc + 1) % DEPTH;
        res.pc  = prog_pc[9:0];
    endfunction

    // mostly low registers so that results feed later instructions
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // random instruction that keeps the program running
    function automatic logic [31:0] pick_word();
        int          sel;
        int          tgt;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [15:0] imm;
        bit          taken;

        if (syscall_armed)
        begin
            syscall_armed = 1'b0;
            return {OP_SPECIAL, 20'($urandom), FN_SYSCALL};
        end
        rs  = pick_reg();
        rt  = pick_reg();
        imm = pick_imm();
        sel = $urandom_range(0, 99);

        if (sel < 30)
        begin
            case ($urandom_range(0, 4))
                0:       fn = FN_ADD;
                1:       fn = FN_SUB;
                2:       fn = FN_AND;
                3:       fn = FN_OR;
                default: fn = FN_SLT;
            endcase
            return r_word(OP_SPECIAL, rs, rt, pick_reg(), 5'($urandom), fn);
        end
        if (sel < 38)
            return r_word(OP_SPECIAL2, rs, rt, pick_reg(), 5'($urandom), FN_MUL);
        if (sel < 75)
        begin
            case ($urandom_range(0, 4))
                0:       op = OP_ADDI;
                1:       op = OP_SLTI;
                2:       op = OP_ANDI;
                3:       op = OP_ORI;
                default: op = OP_LUI;
            endcase
            return i_word(op, rs, rt, imm);
        end
        if (sel < 92)
        begin
            // taken branches get a target inside the program
            if ($urandom_range(0, 3) == 0)
                rt = rs;
            op    = $urandom_range(0, 1) ? OP_BEQ : OP_BNE;
            taken = (op == OP_BEQ) ? (gpr[rs] == gpr[rt]) : (gpr[rs] != gpr[rt]);
            if (taken)
            begin
                case ($urandom_range(0, 9))
                    0:       tgt = 0;
                    1:       tgt = DEPTH - 1;
                    default: tgt = prog_pc + $urandom_range(0, 40) - 20;
                endcase
                if (tgt < 0)
                    tgt = 0;
                if (tgt >= DEPTH)
                    tgt = DEPTH - 1;
                imm = 16'(tgt - prog_pc);
            end
            return i_word(op, rs, rt, imm);
        end
        // print service: load v0 first when it holds something else
        if (gpr[REG_V0] == SYS_PRINT_INT || gpr[REG_V0] == SYS_PRINT_CHAR)
            return {OP_SPECIAL, 20'($urandom), FN_SYSCALL};
        syscall_armed = 1'b1;
        return i_word(OP_ADDI, 5'd0, REG_V0,
                      $urandom_range(0, 1) ? SYS_PRINT_INT[15:0] : SYS_PRINT_CHAR[15:0]);
    endfunction

    // one input transfer, with random gaps between bursts
    task automatic send_step(input step_row_t row);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cur_row     = row;
        instruction = row.word;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // result check and prediction on accepted transfers
    always @(posedge clk)
    begin : monitor_blk
        result_t want;
        result_t got_pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none pending: next_pc %0d event %0d value %h",
                             $time, next_pc, event_res, event_value);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (next_pc !== want.pc)
                    begin
                        $display("%0t: next_pc expected %0d actual %0d",
                                 $time, want.pc, next_pc);
                        mismatches++;
                    end
                    if (event_res !== want.ev)
                    begin
                        $display("%0t: event_res expected %0d actual %0d",
                                 $time, want.ev, event_res);
                        mismatches++;
                    end
                    if (event_value !== want.val)
                    begin
                        $display("%0t: event_value expected %h actual %h",
                                 $time, want.val, event_value);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                execute_word(instruction, got_pred);
                if (cur_row.typed)
                    got_pred = '{cur_row.pc, cur_row.ev, cur_row.val};
                pending_results.push_back(got_pred);
            end
        end
    end

    // receiver stall patterns
    initial
    begin
        int mode;
        int len;
        int k;
        out_stall = 1'b0;
        k = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len)
            begin
                @(negedge clk);
                k++;
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 3) == 0);
                    2:       out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = (k % 4 != 0);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin
        step_row_t   tail [$];
        logic [15:0] imm;
        int          off;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        instruction   = '0;
        cur_row       = plain(32'h0);
        mismatches    = 0;
        burst_left    = 0;
        syscall_armed = 1'b0;
        prog_pc       = 0;
        halted        = 1'b0;
        foreach (gpr[i])
            gpr[i] = 32'h0;

        // directed program: extremes, every operation, branches, prints, wrap
        directed_steps = '{
            typed(i_word(OP_LUI, 0, 8, 16'hFFFF), 10'd1, EV_NONE, 32'h0),
            plain(i_word(OP_ORI, 8, 8, 16'hFFFF)),
            plain(i_word(OP_ADDI, 0, 9, 16'h7FFF)),
            plain(i_word(OP_ADDI, 0, 10, 16'h8000)),
            plain(r_word(OP_SPECIAL, 8, 8, REG_A0, 0, FN_ADD)),
            plain(i_word(OP_LUI, 0, 12, 16'h8000)),
            plain(r_word(OP_SPECIAL, 0, 12, 13, 0, FN_SUB)),
            plain(i_word(OP_ADDI, 12, 14, 16'hFFFF)),
            plain(r_word(OP_SPECIAL2, 14, 14, 16, 0, FN_MUL)),
            plain(r_word(OP_SPECIAL2, 12, 8, 17, 0, FN_MUL)),
            plain(r_word(OP_SPECIAL, 8, 9, 18, 0, FN_AND)),
            plain(r_word(OP_SPECIAL, 12, 9, 19, 0, FN_OR)),
            plain(r_word(OP_SPECIAL, 12, 14, 20, 0, FN_SLT)),
            plain(i_word(OP_SLTI, 12, 22, 16'h8000)),
            plain(i_word(OP_ANDI, 8, 24, 16'hFFFF)),
            plain(r_word(OP_SPECIAL, 8, 8, 0, 0, FN_ADD)),
            typed(i_word(OP_BEQ, 0, 0, 16'd2), 10'd18, EV_NONE, 32'h0),
            typed(i_word(OP_BNE, 0, 0, 16'h8000), 10'd19, EV_NONE, 32'h0),
            typed(i_word(OP_BNE, 8, 0, 16'hFFFD), 10'd16, EV_NONE, 32'h0),
            plain(i_word(OP_ADDI, 0, REG_V0, SYS_PRINT_INT[15:0])),
            typed({OP_SPECIAL, 20'h0, FN_SYSCALL}, 10'd18, EV_PINT, 32'hFFFF_FFFE),
            plain(i_word(OP_ADDI, 0, REG_V0, SYS_PRINT_CHAR[15:0])),
            typed({OP_SPECIAL, 20'hFFFFF, FN_SYSCALL}, 10'd20, EV_PCHAR, 32'hFFFF_FFFE),
            typed(i_word(OP_BEQ, 0, 0, 16'd0), 10'd20, EV_NONE, 32'h0),
            typed(i_word(OP_BEQ, 0, 0, 16'd1003), 10'd1023, EV_NONE, 32'h0),
            typed(r_word(OP_SPECIAL, 0, 0, 3, 0, FN_ADD), 10'd0, EV_NONE, 32'h0)
        };

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
            send_step(directed_steps[i]);

        // random programs, with a full drain now and then
        for (int n = 0; n < 1600; n++)
        begin
            if (n == 800 || $urandom_range(0, 249) == 0)
                drain_results();
            send_step(plain(pick_word()));
        end

        // one halting instruction, chosen by the seed
        case ($urandom_range(0, 4))
            0: tail.push_back(plain(32'h0000_0000));
            1: tail.push_back(plain(32'hFFFF_FFFF));
            2:
            begin
                tail.push_back(plain(i_word(OP_ADDI, 0, REG_V0, SYS_EXIT[15:0])));
                tail.push_back(plain({OP_SPECIAL, 20'($urandom), FN_SYSCALL}));
            end
            3:
            begin
                imm = 16'($urandom);
                if (imm == SYS_PRINT_INT[15:0] || imm == SYS_EXIT[15:0] ||
                    imm == SYS_PRINT_CHAR[15:0])
                    imm = imm + 16'd2;
                tail.push_back(plain(i_word(OP_ADDI, 0, REG_V0, imm)));
                tail.push_back(plain({OP_SPECIAL, 20'($urandom), FN_SYSCALL}));
            end
            default:
            begin
                // taken branch landing outside the program
                case ($urandom_range(0, 3))
                    0:       off = -32768;
                    1:       off = 32767;
                    2:       off = -(prog_pc + 1 + $urandom_range(0, 50));
                    default: off = DEPTH - prog_pc + $urandom_range(0, 50);
                endcase
                tail.push_back(plain(i_word($urandom_range(0, 1) ? OP_BEQ : OP_BNE,
                                            0, 0, 16'(off))));
                if (tail[0].word[31:26] == OP_BNE)
                    tail[0].word[20:16] = 5'd0;
            end
        endcase
        // a bne on equal registers never branches, so make it a beq
        if (tail[0].word[31:26] == OP_BNE)
            tail[0].word[31:26] = OP_BEQ;

        // words after the halt are ignored
        tail.push_back(plain(32'h0000_0000));
        tail.push_back(plain(32'hFFFF_FFFF));
        repeat (18)
            tail.push_back(plain($urandom));
        foreach (tail[i])
            send_step(tail[i]);

        drain_results();
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
